>>> rtl/srpp_pkg.sv
// Shared types and constants for the sensor response packet parser.
// Used by srpp_parser, srpp_out_buf and the top level; no dependencies.
package srpp_pkg;

    // Start word after reset: high byte first.
    localparam logic [15:0] SYNC_WORD_RESET = 16'hEF01;

    // The length field counts the two checksum bytes as well.
    localparam logic [15:0] LEN_OVERHEAD = 16'd2;

    // One result transaction toward the output channel.
    typedef struct packed {
        logic        frame_end;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  packet_type;
        logic        checksum_ok;
        logic [7:0]  last_confirmation;
    } t_result;

    // Occupancy of the output buffer.
    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } t_buf_status;

endpackage

>>> rtl/sensor_response_packet_parser_top.sv
// Top level of the sensor response packet parser.
// Instantiates srpp_parser and srpp_out_buf; uses srpp_pkg.

// Parses the response frames of a serial sensor one received byte per
// transaction. It hunts for the two-byte start word (i_cfg_wr_data written
// with i_cfg_wr_en, high byte first, 0xEF01 after reset), skips
// ADDRESS_BYTES address bytes, then reads the packet type and the 16-bit
// big-endian length. Every payload byte (length minus two, none for a length
// of two or less) leaves as one result transaction with its index; after the
// two checksum bytes one end-of-frame transaction reports whether the 16-bit
// wrapping sum of type, length and payload matched. The first payload byte
// of a frame that passes becomes the last confirmation code. Rate: one byte
// every cycle while the skid stage is empty. The phase machine and checksum
// adder work combinationally; the result register, or the skid stage when
// that register is full, holds the result. i_valid/o_stall and o_valid/i_stall
// are valid/stall handshakes; a result register plus a one-entry skid stage
// let the input keep flowing while a result waits, and o_stall rises only
// when both are occupied. Write the start word only while no frame is in flight.
module sensor_response_packet_parser_top #(
    parameter int ADDRESS_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // received byte channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_end,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_index,
    output logic [7:0]  o_packet_type,
    output logic        o_checksum_ok,
    output logic [7:0]  o_last_confirmation
);

    logic                  in_accept;
    logic                  res_valid;
    srpp_pkg::t_result     res;
    srpp_pkg::t_result     out_data;
    srpp_pkg::t_buf_status buf_status;

    // Take a byte whenever the skid stage has room.
    assign in_accept = i_valid && !buf_status.skid_valid;

    srpp_parser #(
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_byte        (i_rx_byte),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    srpp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_data (res),
        .i_stall     (i_stall),
        .o_data      (out_data),
        .o_status    (buf_status)
    );

    // Drive the ports from the result register.
    assign o_stall             = buf_status.skid_valid;
    assign o_valid             = buf_status.out_valid;
    assign o_frame_end         = out_data.frame_end;
    assign o_payload_byte      = out_data.payload_byte;
    assign o_payload_index     = out_data.payload_index;
    assign o_packet_type       = out_data.packet_type;
    assign o_checksum_ok       = out_data.checksum_ok;
    assign o_last_confirmation = out_data.last_confirmation;

`ifndef SYNTHESIS
    // The skid stage only fills behind an occupied result register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid stage full while result register empty");

    // Fields unused by each result kind stay zero.
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_end ? (o_payload_byte == 8'h00 && o_payload_index == 16'h0000)
                                 : !o_checksum_ok))
        else $error("unused result field not zero");

    // Reset empties both output stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output buffer not empty after reset");
`endif

endmodule

>>> rtl/srpp_parser.sv
// Byte-level frame parser: phase machine, checksum and confirmation latch.
// Depends on srpp_pkg for the result type and constants.
module srpp_parser #(
    parameter int ADDRESS_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output srpp_pkg::t_result o_res
);

    typedef enum logic [3:0] {
        PH_HUNT_HI = 4'd0,
        PH_HUNT_LO = 4'd1,
        PH_ADDR    = 4'd2,
        PH_TYPE    = 4'd3,
        PH_LEN_HI  = 4'd4,
        PH_LEN_LO  = 4'd5,
        PH_DATA    = 4'd6,
        PH_CHK_HI  = 4'd7,
        PH_CHK_LO  = 4'd8
    } t_phase;

    localparam logic [15:0] ADDR_LAST = 16'(ADDRESS_BYTES);

    t_phase      r_phase, n_phase;
    logic [15:0] r_sync_word;
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_payload_length, n_payload_length;
    logic [15:0] r_running_sum, n_running_sum;
    logic        r_high_match, n_high_match;
    logic [7:0]  r_type_seen, n_type_seen;
    logic [7:0]  r_frame_code, n_frame_code;
    logic [7:0]  r_confirmed_code, n_confirmed_code;

    logic [15:0] count_inc;
    logic [15:0] sum_add;
    logic [15:0] full_len;
    logic        chk_ok;

    assign count_inc = 16'(r_byte_count + 16'd1);
    assign sum_add   = 16'(r_running_sum + {8'h00, i_byte});
    assign full_len  = r_payload_length | {8'h00, i_byte};
    assign chk_ok    = r_high_match && (i_byte == r_running_sum[7:0]);

    always_comb begin
        n_phase          = r_phase;
        n_byte_count     = r_byte_count;
        n_payload_length = r_payload_length;
        n_running_sum    = r_running_sum;
        n_high_match     = r_high_match;
        n_type_seen      = r_type_seen;
        n_frame_code     = r_frame_code;
        n_confirmed_code = r_confirmed_code;
        o_res_valid      = 1'b0;
        o_res            = '{frame_end: 1'b0, payload_byte: 8'h00, payload_index: 16'h0000,
                             packet_type: r_type_seen, checksum_ok: 1'b0,
                             last_confirmation: r_confirmed_code};
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT_HI: begin
                    if (i_byte == r_sync_word[15:8]) n_phase = PH_HUNT_LO;
                end
                PH_HUNT_LO: begin
                    // A miss goes back to hunting; this byte is not retried.
                    if (i_byte == r_sync_word[7:0]) begin
                        n_phase      = PH_ADDR;
                        n_byte_count = 16'h0000;
                    end else begin
                        n_phase = PH_HUNT_HI;
                    end
                end
                PH_ADDR: begin
                    n_byte_count = count_inc;
                    if (count_inc >= ADDR_LAST) n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type_seen   = i_byte;
                    n_running_sum = {8'h00, i_byte};
                    n_phase       = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_running_sum    = sum_add;
                    n_payload_length = {i_byte, 8'h00};
                    n_phase          = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_running_sum = sum_add;
                    // Clamp short lengths to an empty payload.
                    n_payload_length = (full_len > srpp_pkg::LEN_OVERHEAD)
                                     ? 16'(full_len - srpp_pkg::LEN_OVERHEAD) : 16'h0000;
                    n_byte_count = 16'h0000;
                    n_phase = (full_len > srpp_pkg::LEN_OVERHEAD) ? PH_DATA : PH_CHK_HI;
                end
                PH_DATA: begin
                    n_running_sum = sum_add;
                    if (r_byte_count == 16'h0000) n_frame_code = i_byte;
                    o_res_valid         = 1'b1;
                    o_res.payload_byte  = i_byte;
                    o_res.payload_index = r_byte_count;
                    n_byte_count        = count_inc;
                    if (count_inc >= r_payload_length) n_phase = PH_CHK_HI;
                end
                PH_CHK_HI: begin
                    n_high_match = (i_byte == r_running_sum[15:8]);
                    n_phase      = PH_CHK_LO;
                end
                PH_CHK_LO: begin
                    // Latch the confirmation code only for a good, non-empty frame.
                    if (chk_ok && (r_payload_length != 16'h0000)) n_confirmed_code = r_frame_code;
                    o_res_valid             = 1'b1;
                    o_res.frame_end         = 1'b1;
                    o_res.checksum_ok       = chk_ok;
                    o_res.last_confirmation = n_confirmed_code;
                    n_phase                 = PH_HUNT_HI;
                end
                default: begin
                    n_phase = PH_HUNT_HI;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HUNT_HI;
            r_sync_word      <= srpp_pkg::SYNC_WORD_RESET;
            r_byte_count     <= 16'h0000;
            r_payload_length <= 16'h0000;
            r_running_sum    <= 16'h0000;
            r_high_match     <= 1'b0;
            r_type_seen      <= 8'h00;
            r_frame_code     <= 8'h00;
            r_confirmed_code <= 8'h00;
        end else begin
            r_phase          <= n_phase;
            r_byte_count     <= n_byte_count;
            r_payload_length <= n_payload_length;
            r_running_sum    <= n_running_sum;
            r_high_match     <= n_high_match;
            r_type_seen      <= n_type_seen;
            r_frame_code     <= n_frame_code;
            r_confirmed_code <= n_confirmed_code;
            if (i_cfg_wr_en) r_sync_word <= i_cfg_wr_data;
        end
    end

endmodule

>>> rtl/srpp_out_buf.sv
// Result register with a one-entry skid stage behind it.
// Depends on srpp_pkg for the result and status types.
module srpp_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  srpp_pkg::t_result     i_push_data,
    input  logic                  i_stall,
    output srpp_pkg::t_result     o_data,
    output srpp_pkg::t_buf_status o_status
);

    logic              r_out_valid;
    logic              r_skid_valid;
    srpp_pkg::t_result r_out_data;
    srpp_pkg::t_result r_skid_data;
    logic              pop;

    assign pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                // Advance the waiting transaction; no push while the skid is full.
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_out_data <= i_push_data;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_data  <= i_push_data;
                r_skid_valid <= 1'b1;
            end else begin
                r_out_data  <= i_push_data;
                r_out_valid <= 1'b1;
            end
        end
    end

    assign o_data              = r_out_data;
    assign o_status.out_valid  = r_out_valid;
    assign o_status.skid_valid = r_skid_valid;

endmodule
